// File: rtl/core/ntwa_pkg.sv
package ntwa_pkg;

    // table geometry; one slot is always kept spare, so at most TABLE_CAP entries are held
    localparam int TABLE_SIZE = 16;
    localparam int TABLE_CAP  = TABLE_SIZE - 1;
    localparam int IDX_W      = $clog2(TABLE_SIZE);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPLORER_TYPE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAREST_CEIL  = 3'd3;

    // register reset values
    localparam logic [15:0] OWN_ID_RST        = 16'd0;
    localparam logic [2:0]  EXPLORER_TYPE_RST = 3'd3;
    localparam logic [7:0]  AGE_LIMIT_RST     = 8'd64;
    localparam logic [7:0]  NEAREST_CEIL_RST  = 8'd90;

    // request opcodes
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_PURGE  = 1'b1;

    // one table entry: key and tick, then the payload bytes
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] tick;
        logic [7:0]  fd_range;
        logic [7:0]  fd_sign;
        logic [7:0]  fd_angle;
        logic [7:0]  stype;
        logic [7:0]  ncount;
        logic [7:0]  distance;
    } entry_t;

    // scan control towards the summary accumulator
    typedef struct packed {
        logic clear;
        logic valid;
    } scan_ctl_t;

    typedef struct packed {
        logic [7:0] nearest;
        logic [7:0] mask;
        logic       higher;
        logic       fvalid;
        logic [7:0] fang;
        logic [7:0] fsign;
        logic [7:0] fdist;
    } summary_t;

endpackage

// File: rtl/core/neighbor_table_with_aging_unit.sv
// Neighbour table with aging.
// Input channel (in_valid / in_stall): one request per item. opcode 0 records a
// message (search by sender_id, update the match or append); opcode 1 purges
// entries whose age (now_ticks - stored tick, modulo 2^32) exceeds age_limit.
// Output channel (out_valid / out_stall): one summary per request: entry count,
// nearest distance, type mask, higher-explorer flag and food bytes of the last
// entry carrying a food angle.
// A record scans the stored entries for sender_id, writes the entry, then scans
// the table again for the summary; a purge reads and checks each entry from the
// top down, moving the last entry into each hole, then scans for the summary.
// The search and summary scans go through the one read port of the memory, one entry per
// cycle; a purge check is a read and a compare state, a removal adds a move
// state. One request is in progress at a time; the next is taken in the cycle
// after a summary is loaded, and that summary waits in the output register.
// Reset empties the table (count zero) and loads register defaults; the memory
// itself is not cleared, only entries below the count are ever read.
// A stalled summary is held unchanged; a request finished meanwhile waits in its
// last state until the output register frees.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
module neighbor_table_with_aging_unit
    import ntwa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  opcode,
    input  logic [15:0]           sender_id,
    input  logic [7:0]            sender_distance,
    input  logic [7:0]            sender_neighbor_count,
    input  logic [7:0]            sender_type,
    input  logic [7:0]            food_angle_in,
    input  logic [7:0]            food_sign_in,
    input  logic [7:0]            food_dist_in,
    input  logic [31:0]           now_ticks,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [3:0]            entry_count,
    output logic [7:0]            nearest_distance,
    output logic [7:0]            type_present_mask,
    output logic                  higher_explorer_seen,
    output logic                  food_info_valid,
    output logic [7:0]            food_angle_out,
    output logic [7:0]            food_sign_out,
    output logic [7:0]            food_dist_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_WRITE,
        S_P_RD,
        S_P_CHK,
        S_P_MOVE,
        S_SUM,
        S_DONE
    } state_t;

    // entry memory, registered read
    entry_t mem [TABLE_SIZE];
    entry_t rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    entry_t           mem_wdata;

    state_t           state_reg,     state_next;
    logic [IDX_W-1:0] count_reg,     count_next;
    logic [IDX_W-1:0] idx_reg,       idx_next;      // next entry to read
    logic             cmp_valid_reg, cmp_valid_next; // rd_data_reg holds a scanned entry
    logic [IDX_W-1:0] cmp_idx_reg,   cmp_idx_next;
    logic             found_reg,     found_next;
    logic [IDX_W-1:0] slot_reg,      slot_next;
    entry_t           item_reg,      item_next;

    logic [15:0]      own_id_reg;
    logic [2:0]       explorer_type_reg;
    logic [7:0]       age_limit_reg;
    logic [7:0]       nearest_ceil_reg;

    logic             out_valid_reg, out_valid_next;
    logic [3:0]       out_count_reg, out_count_next;
    summary_t         out_sum_reg,   out_sum_next;

    scan_ctl_t        scan_ctl;
    summary_t         sum_result;

    logic             in_take;
    logic             out_free;
    logic [31:0]      age;
    logic             aged;

    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign age      = item_reg.tick - rd_data_reg.tick;
    assign aged     = age > {24'd0, age_limit_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        item_next      = item_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_count_next = out_count_reg;
        out_sum_next   = out_sum_reg;
        mem_we         = 1'b0;
        mem_waddr      = slot_reg;
        mem_wdata      = item_reg;
        mem_raddr      = idx_reg;
        scan_ctl.clear = 1'b1;
        scan_ctl.valid = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    item_next.id       = sender_id;
                    item_next.tick     = now_ticks;
                    item_next.distance = sender_distance;
                    item_next.ncount   = sender_neighbor_count;
                    item_next.stype    = sender_type;
                    item_next.fd_angle = food_angle_in;
                    item_next.fd_sign  = food_sign_in;
                    item_next.fd_range = food_dist_in;
                    found_next         = 1'b0;
                    if (opcode == OP_PURGE)
                    begin
                        idx_next   = count_reg;
                        state_next = S_P_RD;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                // issue one read per cycle, compare the previous one
                if (idx_reg < count_reg)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = idx_reg;
                    idx_next       = idx_reg + 1'b1;
                end
                if (cmp_valid_reg && (rd_data_reg.id == item_reg.id))
                begin
                    found_next     = 1'b1;
                    slot_next      = cmp_idx_reg;
                    cmp_valid_next = 1'b0;
                    state_next     = S_WRITE;
                end
                else if ((idx_reg >= count_reg) && !cmp_valid_reg)
                begin
                    state_next = S_WRITE;
                end
            end

            S_WRITE:
            begin
                mem_we = 1'b1;
                if (found_reg)
                begin
                    mem_waddr = slot_reg;
                end
                else if (count_reg < IDX_W'(TABLE_CAP))
                begin
                    mem_waddr  = count_reg;
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    // full: the newcomer replaces the last entry
                    mem_waddr = count_reg - 1'b1;
                end
                idx_next   = '0;
                state_next = S_SUM;
            end

            S_P_RD:
            begin
                if (idx_reg == '0)
                begin
                    state_next = S_SUM;
                end
                else
                begin
                    mem_raddr  = idx_reg - 1'b1;
                    idx_next   = idx_reg - 1'b1;
                    state_next = S_P_CHK;
                end
            end

            S_P_CHK:
            begin
                if (aged)
                begin
                    mem_raddr  = count_reg - 1'b1;
                    state_next = S_P_MOVE;
                end
                else
                begin
                    state_next = S_P_RD;
                end
            end

            S_P_MOVE:
            begin
                // last entry fills the hole
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = rd_data_reg;
                count_next = count_reg - 1'b1;
                state_next = S_P_RD;
            end

            S_SUM:
            begin
                scan_ctl.clear = 1'b0;
                scan_ctl.valid = cmp_valid_reg;
                if (idx_reg < count_reg)
                begin
                    cmp_valid_next = 1'b1;
                    idx_next       = idx_reg + 1'b1;
                end
                else if (!cmp_valid_reg)
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                scan_ctl.clear = 1'b0;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    out_sum_next   = sum_result;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            count_reg         <= '0;
            idx_reg           <= '0;
            cmp_valid_reg     <= 1'b0;
            found_reg         <= 1'b0;
            out_valid_reg     <= 1'b0;
            out_count_reg     <= '0;
            out_sum_reg       <= '0;
            own_id_reg        <= OWN_ID_RST;
            explorer_type_reg <= EXPLORER_TYPE_RST;
            age_limit_reg     <= AGE_LIMIT_RST;
            nearest_ceil_reg  <= NEAREST_CEIL_RST;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            out_count_reg <= out_count_next;
            out_sum_reg   <= out_sum_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_OWN_ID:        own_id_reg        <= cfg_data;
                    CFG_EXPLORER_TYPE: explorer_type_reg <= cfg_data[2:0];
                    CFG_AGE_LIMIT:     age_limit_reg     <= cfg_data[7:0];
                    CFG_NEAREST_CEIL:  nearest_ceil_reg  <= cfg_data[7:0];
                    default:           ;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        slot_reg    <= slot_next;
        item_reg    <= item_next;
    end

    ntwa_summary u_summary (
        .clk             (clk),
        .ctl             (scan_ctl),
        .entry           (rd_data_reg),
        .own_id          (own_id_reg),
        .explorer_type   (explorer_type_reg),
        .nearest_ceiling (nearest_ceil_reg),
        .result          (sum_result)
    );

    assign in_stall             = (state_reg != S_IDLE);
    assign out_valid            = out_valid_reg;
    assign entry_count          = out_count_reg;
    assign nearest_distance     = out_sum_reg.nearest;
    assign type_present_mask    = out_sum_reg.mask;
    assign higher_explorer_seen = out_sum_reg.higher;
    assign food_info_valid      = out_sum_reg.fvalid;
    assign food_angle_out       = out_sum_reg.fang;
    assign food_sign_out        = out_sum_reg.fsign;
    assign food_dist_out        = out_sum_reg.fdist;

endmodule

// File: rtl/core/ntwa_summary.sv
module ntwa_summary
    import ntwa_pkg::*;
(
    input  logic        clk,
    input  scan_ctl_t   ctl,
    input  entry_t      entry,
    input  logic [15:0] own_id,
    input  logic [2:0]  explorer_type,
    input  logic [7:0]  nearest_ceiling,
    output summary_t    result
);

    summary_t acc_reg;
    summary_t acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next         = '0;
            acc_next.nearest = nearest_ceiling;
        end
        else if (ctl.valid)
        begin
            if (entry.distance < acc_reg.nearest)
            begin
                acc_next.nearest = entry.distance;
            end
            if (entry.stype[7:3] == 5'd0)
            begin
                acc_next.mask = acc_reg.mask | (8'd1 << entry.stype[2:0]);
            end
            if ((entry.stype == {5'd0, explorer_type}) && (entry.id > own_id))
            begin
                acc_next.higher = 1'b1;
            end
            // last entry with a food angle wins
            if (entry.fd_angle != 8'd0)
            begin
                acc_next.fvalid = 1'b1;
                acc_next.fang   = entry.fd_angle;
                acc_next.fsign  = entry.fd_sign;
                acc_next.fdist  = entry.fd_range;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign result = acc_reg;

endmodule

// File: rtl/core/ntwa_checker.sv
module ntwa_checker
    import ntwa_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [3:0] entry_count,
    input logic [7:0] type_present_mask,
    input logic       higher_explorer_seen,
    input logic       food_info_valid,
    input logic [7:0] food_angle_out,
    input logic [7:0] food_sign_out,
    input logic [7:0] food_dist_out
);

    // one request at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while another is in progress");

    a_empty_summary: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (entry_count == 4'd0) |-> (type_present_mask == 8'd0) && !food_info_valid)
        else $error("empty table reports entries");

    a_no_food_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !food_info_valid |->
            (food_angle_out == 8'd0) && (food_sign_out == 8'd0) && (food_dist_out == 8'd0))
        else $error("food bytes set without food entry");

    a_explorer_typed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && higher_explorer_seen |-> (type_present_mask != 8'd0))
        else $error("explorer reported with empty type mask");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(entry_count) && $stable(food_angle_out))
        else $error("stalled summary changed");

endmodule

bind neighbor_table_with_aging_unit ntwa_checker u_ntwa_checker (.*);

// File: dv/neighbor_table_with_aging_unit_tb.sv
module neighbor_table_with_aging_unit_tb;
    import ntwa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one request as offered on the input channel
    typedef struct {
        bit          op;
        bit [15:0]   id;
        bit [7:0]    distance;
        bit [7:0]    ncnt;
        bit [7:0]    styp;
        bit [7:0]    fang;
        bit [7:0]    fsign;
        bit [7:0]    fdist;
        bit [31:0]   now;
    } req_t;

    // table summary returned for every request
    typedef struct {
        logic [3:0]  count;
        logic [7:0]  nearest;
        logic [7:0]  mask;
        logic        higher;
        logic        fvalid;
        logic [7:0]  fang;
        logic [7:0]  fsign;
        logic [7:0]  fdist;
    } nbr_summary_t;

    localparam int HOLD_CYCLES = 400;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;

    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  opcode = OP_RECORD;
    logic [15:0]           sender_id = '0;
    logic [7:0]            sender_distance = '0;
    logic [7:0]            sender_neighbor_count = '0;
    logic [7:0]            sender_type = '0;
    logic [7:0]            food_angle_in = '0;
    logic [7:0]            food_sign_in = '0;
    logic [7:0]            food_dist_in = '0;
    logic [31:0]           now_ticks = '0;

    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [3:0]            entry_count;
    logic [7:0]            nearest_distance;
    logic [7:0]            type_present_mask;
    logic                  higher_explorer_seen;
    logic                  food_info_valid;
    logic [7:0]            food_angle_out;
    logic [7:0]            food_sign_out;
    logic [7:0]            food_dist_out;

    neighbor_table_with_aging_unit u_top (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_we                (cfg_we),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .opcode                (opcode),
        .sender_id             (sender_id),
        .sender_distance       (sender_distance),
        .sender_neighbor_count (sender_neighbor_count),
        .sender_type           (sender_type),
        .food_angle_in         (food_angle_in),
        .food_sign_in          (food_sign_in),
        .food_dist_in          (food_dist_in),
        .now_ticks             (now_ticks),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .entry_count           (entry_count),
        .nearest_distance      (nearest_distance),
        .type_present_mask     (type_present_mask),
        .higher_explorer_seen  (higher_explorer_seen),
        .food_info_valid       (food_info_valid),
        .food_angle_out        (food_angle_out),
        .food_sign_out         (food_sign_out),
        .food_dist_out         (food_dist_out)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the neighbour table and its registers
    // ------------------------------------------------------------------
    entry_t       nbr_tbl[TABLE_SIZE];
    int           nbr_count = 0;
    logic [15:0]  shadow_own_id = OWN_ID_RST;
    logic [2:0]   shadow_expl_type = EXPLORER_TYPE_RST;
    logic [7:0]   shadow_age_limit = AGE_LIMIT_RST;
    logic [7:0]   shadow_ceiling = NEAREST_CEIL_RST;

    req_t         pending_reqs[$];    // requests waiting for the driver
    nbr_summary_t summary_q[$];       // summaries owed by the block, oldest first
    req_t         offered_req;        // request currently on the input port

    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_token = 0;     // bumped by the stimulus to ask for a long hold-off
    int           hold_seen = 0;
    int           hold_left = 0;
    int           err_count = 0;

    bit [31:0]    tick_now;
    bit [15:0]    id_pool[24];

    // Apply one request to the shadow table and return the summary it yields.
    function automatic nbr_summary_t apply_request(input req_t r);
        nbr_summary_t s;
        int           slot;
        bit [31:0]    age;
        slot = -1;
        if (r.op == OP_RECORD)
        begin
            for (int i = 0; i < nbr_count; i++)
                if (slot < 0 && nbr_tbl[i].id == r.id)
                    slot = i;
            if (slot < 0)
            begin
                // no match: append, or if the table is full the newcomer takes over the last slot, count unchanged
                if (nbr_count < TABLE_CAP)
                begin
                    slot = nbr_count;
                    nbr_count++;
                end
                else
                    slot = nbr_count - 1;
            end
            nbr_tbl[slot].id       = r.id;
            nbr_tbl[slot].tick     = r.now;
            nbr_tbl[slot].distance = r.distance;
            nbr_tbl[slot].ncount   = r.ncnt;
            nbr_tbl[slot].stype    = r.styp;
            nbr_tbl[slot].fd_angle = r.fang;
            nbr_tbl[slot].fd_sign  = r.fsign;
            nbr_tbl[slot].fd_range = r.fdist;
        end
        else
        begin
            // top-down; the entry moved into a hole has been checked already
            for (int i = nbr_count - 1; i >= 0; i--)
            begin
                age = r.now - nbr_tbl[i].tick;
                if (age > {24'd0, shadow_age_limit})
                begin
                    nbr_tbl[i] = nbr_tbl[nbr_count - 1];
                    nbr_count--;
                end
            end
        end

        s.count   = 4'(nbr_count);
        s.nearest = shadow_ceiling;
        s.mask    = '0;
        s.higher  = 1'b0;
        s.fvalid  = 1'b0;
        s.fang    = '0;
        s.fsign   = '0;
        s.fdist   = '0;
        for (int i = 0; i < nbr_count; i++)
        begin
            if (nbr_tbl[i].distance < s.nearest)
                s.nearest = nbr_tbl[i].distance;
            if (nbr_tbl[i].stype < 8)
                s.mask[nbr_tbl[i].stype[2:0]] = 1'b1;
            if (nbr_tbl[i].stype == {5'd0, shadow_expl_type} && nbr_tbl[i].id > shadow_own_id)
                s.higher = 1'b1;
            if (nbr_tbl[i].fd_angle != 8'd0)
            begin
                s.fvalid = 1'b1;
                s.fang   = nbr_tbl[i].fd_angle;
                s.fsign  = nbr_tbl[i].fd_sign;
                s.fdist  = nbr_tbl[i].fd_range;
            end
        end
        return s;
    endfunction

    task automatic report_fault(input string msg);
        err_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_fault($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Driver: takes the next request when the port is free, holds it while stalled
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                summary_q.push_back(apply_request(offered_req));
            if (!in_valid || !in_stall)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered_req            = pending_reqs.pop_front();
                    in_valid              <= 1'b1;
                    opcode                <= offered_req.op;
                    sender_id             <= offered_req.id;
                    sender_distance       <= offered_req.distance;
                    sender_neighbor_count <= offered_req.ncnt;
                    sender_type           <= offered_req.styp;
                    food_angle_in         <= offered_req.fang;
                    food_sign_in          <= offered_req.fsign;
                    food_dist_in          <= offered_req.fdist;
                    now_ticks             <= offered_req.now;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted summary and drives the output stall
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : mon
        nbr_summary_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (summary_q.size() == 0)
                    report_fault("summary with none outstanding");
                else
                begin
                    want = summary_q.pop_front();
                    check_field("entry_count", 32'(entry_count), 32'(want.count));
                    check_field("nearest_distance", 32'(nearest_distance),
                                32'(want.nearest));
                    check_field("type_present_mask", 32'(type_present_mask),
                                32'(want.mask));
                    check_field("higher_explorer_seen", 32'(higher_explorer_seen),
                                32'(want.higher));
                    check_field("food_info_valid", 32'(food_info_valid), 32'(want.fvalid));
                    check_field("food_angle_out", 32'(food_angle_out), 32'(want.fang));
                    check_field("food_sign_out", 32'(food_sign_out), 32'(want.fsign));
                    check_field("food_dist_out", 32'(food_dist_out), 32'(want.fdist));
                end
            end
            // long hold-off so the block backs up and stalls its input
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic req_t record_req(input bit [15:0] id, input bit [7:0] distance,
                                        input bit [7:0] ncnt, input bit [7:0] styp,
                                        input bit [7:0] fang, input bit [7:0] fsign,
                                        input bit [7:0] fdist, input bit [31:0] now);
        req_t r;
        r.op = OP_RECORD;
        r.id = id;
        r.distance = distance;
        r.ncnt = ncnt;
        r.styp = styp;
        r.fang = fang;
        r.fsign = fsign;
        r.fdist = fdist;
        r.now = now;
        return r;
    endfunction

    // purge: only the tick matters, the rest is junk
    function automatic req_t purge_req(input bit [31:0] now);
        req_t r;
        r = record_req(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom), 8'($urandom), now);
        r.op = OP_PURGE;
        return r;
    endfunction

    // mostly a steady tick and a small set of ids so entries get matched and aged
    function automatic req_t rand_request();
        req_t r;
        if ($urandom_range(99) < 5)
            tick_now = $urandom;                      // tick jump, stale or wrapped
        else
            tick_now += 32'($urandom_range(0, 12));
        r = record_req($urandom_range(99) < 75 ? id_pool[$urandom_range(23)]
                                                : 16'($urandom),
                       8'($urandom), 8'($urandom),
                       $urandom_range(99) < 85 ? 8'($urandom_range(7)) : 8'($urandom),
                       $urandom_range(1) ? 8'($urandom) : 8'd0,
                       8'($urandom), 8'($urandom), tick_now);
        if ($urandom_range(99) < 12)
            r = purge_req(tick_now);
        return r;
    endfunction

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_OWN_ID:        shadow_own_id    = val;
            CFG_EXPLORER_TYPE: shadow_expl_type = val[2:0];
            CFG_AGE_LIMIT:     shadow_age_limit = val[7:0];
            CFG_NEAREST_CEIL:  shadow_ceiling   = val[7:0];
            default:           ;
        endcase
    endtask

    task automatic configure(input logic [15:0] own, input logic [15:0] expl,
                             input logic [15:0] age, input logic [15:0] ceil_v);
        write_cfg(CFG_OWN_ID, own);
        write_cfg(CFG_EXPLORER_TYPE, expl);
        write_cfg(CFG_AGE_LIMIT, age);
        write_cfg(CFG_NEAREST_CEIL, ceil_v);
    endtask

    // sampled on the falling edge so the driver's and monitor's updates have settled
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || summary_q.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic run_phase(input int n_items, input int s_pct, input int r_pct,
                             input bit long_hold);
        @(negedge clk);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        id_pool[0] = shadow_own_id;
        id_pool[1] = shadow_own_id + 16'd1;
        id_pool[2] = shadow_own_id - 16'd1;
        id_pool[3] = 16'h0000;
        id_pool[4] = 16'hFFFF;
        for (int i = 5; i < 24; i++)
            id_pool[i] = 16'($urandom);
        if (long_hold)
            hold_token++;
        repeat (n_items) pending_reqs.push_back(rand_request());
        wait_idle();
    endtask

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < TABLE_SIZE; i++)
            nbr_tbl[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed, register defaults: field extremes, match update, fill to
        // capacity, overwrite of the last entry when full, purges down to empty
        @(negedge clk);
        pending_reqs.push_back(record_req(16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                          8'h00, 32'h0000_0000));
        pending_reqs.push_back(record_req(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                          8'hFF, 32'hFFFF_FFFF));
        // same id again: updated in place, now an explorer above own id, no food
        pending_reqs.push_back(record_req(16'hFFFF, 8'd40, 8'h55, 8'd3, 8'h00, 8'h12,
                                          8'h34, 32'd5));
        for (int k = 1; k <= 13; k++)
            pending_reqs.push_back(record_req(16'(k * 16'h0101), 8'(10 + k * 9),
                                              8'($urandom), 8'(k % 8),
                                              (k % 3 == 0) ? 8'd0 : 8'(k * 17),
                                              8'($urandom), 8'($urandom), 32'(k * 10)));
        // table full: unknown sender overwrites the last entry
        pending_reqs.push_back(record_req(16'h7777, 8'd5, 8'd1, 8'd9, 8'h80, 8'd1,
                                          8'd2, 32'd200));
        pending_reqs.push_back(purge_req(32'd150));
        pending_reqs.push_back(purge_req(32'd150));
        pending_reqs.push_back(purge_req(32'h8000_0000));
        pending_reqs.push_back(purge_req(32'd0));          // purge of an empty table
        pending_reqs.push_back(record_req(16'h1234, 8'd200, 8'd7, 8'd7, 8'd0, 8'd9,
                                          8'd9, 32'd1));
        wait_idle();

        // writes to unused indexes must leave every register alone
        for (int k = CFG_NEAREST_CEIL + 1; k < (1 << CFG_IDX_W); k++)
            write_cfg(CFG_IDX_W'(k), 16'hFFFF);
        tick_now = 32'hFFFF_FF00;                           // starts just below the wrap point
        run_phase(10, 0, 0, 1'b0);

        // extremes: purge anything at least one tick old, ceiling at the top
        configure(16'h0000, 16'hFFF8, 16'h0000, 16'h00FF);
        run_phase(150, 0, 0, 1'b0);

        // other extremes: no id can beat own id, age limit at its largest, ceiling zero
        configure(16'hFFFF, 16'h0007, 16'h00FF, 16'h0000);
        run_phase(150, 82, 0, 1'b0);

        configure(16'($urandom), 16'($urandom), 16'($urandom_range(8, 60)), 16'($urandom));
        tick_now = $urandom;
        run_phase(150, 0, 82, 1'b0);

        configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        run_phase(150, 7, 7, 1'b0);

        // receiver holds off while the sender keeps offering requests
        configure(16'($urandom), 16'($urandom), 16'($urandom_range(20, 120)),
                  16'($urandom));
        run_phase(60, 0, 0, 1'b1);

        configure(16'($urandom), 16'($urandom), 16'($urandom_range(10, 80)),
                  16'($urandom_range(100, 255)));
        tick_now = $urandom;
        run_phase(230, 25, 25, 1'b0);

        repeat (80) @(posedge clk);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
